// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the moving-average RTL.
// Every macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MAVG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// An implication checked in the same cycle.
`define MAVG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Types and fixed constants shared by the moving-average controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

	localparam int SAMPLE_W = 16;

	// Action codes on the request channel.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_START,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear;
		logic ring_rd;
		logic update;
		logic div_start;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mavg_div.sv =====
// ----------------------------------------------------------------------------
// mavg_div
// Restoring divider, one quotient bit per cycle, signed dividend by an
// unsigned divisor, quotient truncated toward zero and cut to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
	parameter int DW = 20,
	parameter int VW = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [DW-1:0]          dividend,
	input  wire logic        [VW-1:0]          divisor,
	output logic                               busy,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dsr_q;
	logic             neg_q;
	logic [DW-1:0]    mag;
	logic [VW:0]      shifted;
	logic [VW:0]      diff;

	assign mag     = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign busy    = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DW-1];
		end else if (busy) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// The magnitude never exceeds 32768, so the low 16 bits carry it exactly.
	assign quotient = neg_q ? -$signed(quo_q[mavg_pkg::SAMPLE_W-1:0])
	                        : $signed(quo_q[mavg_pkg::SAMPLE_W-1:0]);

endmodule

`default_nettype wire

// ===== rtl/core/mavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer for one sample beat: ring read, total update, division and
// hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              action,
	output logic                   req_stall,
	output mavg_pkg::cmd_t         cmd,
	input  wire mavg_pkg::status_t status
);

	mavg_pkg::state_t state_q;
	mavg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mavg_pkg::ST_IDLE: begin
				if (req_valid && action == mavg_pkg::ACT_SAMPLE) begin
					state_d = mavg_pkg::ST_READ;
				end
			end
			mavg_pkg::ST_READ:   state_d = mavg_pkg::ST_UPDATE;
			mavg_pkg::ST_UPDATE: state_d = mavg_pkg::ST_START;
			mavg_pkg::ST_START:  state_d = mavg_pkg::ST_DIVIDE;
			mavg_pkg::ST_DIVIDE: begin
				if (!status.div_busy) begin
					state_d = mavg_pkg::ST_DELIVER;
				end
			end
			mavg_pkg::ST_DELIVER: begin
				if (status.out_free) begin
					state_d = mavg_pkg::ST_IDLE;
				end
			end
			default: state_d = mavg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			mavg_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid && action == mavg_pkg::ACT_SAMPLE;
				cmd.clear   = req_valid && action == mavg_pkg::ACT_CLEAR;
			end
			mavg_pkg::ST_READ:    cmd.ring_rd   = 1'b1;
			mavg_pkg::ST_UPDATE:  cmd.update    = 1'b1;
			mavg_pkg::ST_START:   cmd.div_start = 1'b1;
			mavg_pkg::ST_DIVIDE:  cmd         = '0;
			mavg_pkg::ST_DELIVER: cmd.out_load  = status.out_free;
			default:              cmd         = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mavg_dpath.sv =====
// ----------------------------------------------------------------------------
// mavg_dpath
// Sample ring, running total, write slot, fill count, divider and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mavg_dpath #(
	parameter int WINDOW = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mavg_pkg::cmd_t                        cmd,
	output mavg_pkg::status_t                          status,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
	output logic                                       rsp_valid,
	input  wire logic                                  rsp_stall,
	output logic signed [mavg_pkg::SAMPLE_W-1:0]       average
);

	localparam int SW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int TW = mavg_pkg::SAMPLE_W + $clog2(WINDOW);

	logic signed [mavg_pkg::SAMPLE_W-1:0] ring_mem [WINDOW];
	logic signed [mavg_pkg::SAMPLE_W-1:0] ring_rd_q;
	logic signed [mavg_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [mavg_pkg::SAMPLE_W-1:0] oldest;
	logic signed [mavg_pkg::SAMPLE_W-1:0] quotient;
	logic signed [mavg_pkg::SAMPLE_W-1:0] average_q;
	logic signed [TW-1:0]                 total_q;
	logic        [SW-1:0]                 slot_q;
	logic        [CW-1:0]                 count_q;
	logic                                 full;
	logic                                 rsp_valid_q;
	logic                                 div_busy;

	// Entries are written in slot order after a clear, so the entry at the write
	// slot holds a live sample only once the count has reached the window length.
	assign full   = (count_q == CW'(WINDOW));
	assign oldest = full ? ring_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_rd) begin
			ring_rd_q <= ring_mem[slot_q];
		end
		if (cmd.update) begin
			ring_mem[slot_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			slot_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
			slot_q  <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			total_q <= total_q - TW'(oldest) + TW'(sample_q);
			slot_q  <= (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + SW'(1);
			if (!full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	mavg_div #(
		.DW(TW),
		.VW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (total_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			average_q <= quotient;
		end
	end

	assign status.div_busy = div_busy;
	assign status.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid       = rsp_valid_q;
	assign average         = average_q;

	`MAVG_ASSERT(a_count_bound, count_q <= CW'(WINDOW), "fill count above window")
	`MAVG_ASSERT_IMP(a_warmup_slot, !full, CW'(slot_q) == count_q,
		"write slot out of step with fill count during warm-up")
	`MAVG_ASSERT_IMP(a_div_idle_start, cmd.div_start, !div_busy,
		"divider started while busy")
	`MAVG_ASSERT_IMP(a_load_free, cmd.out_load, !rsp_valid_q || !rsp_stall,
		"result register overwritten while stalled")

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_with_warmup.sv =====
// ----------------------------------------------------------------------------
// moving_average_with_warmup
// Boxcar moving average over the last WINDOW signed 16-bit samples, with a
// warm-up phase that divides by the number of samples seen since a clear.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                        Beat carries
//   -------  -----------------------------  ---------------------------------
//   request  req_valid, req_stall           action (0 sample, 1 clear), sample
//   response rsp_valid, rsp_stall           average
//
// A sample beat passes from acceptance through ring read, total update and
// divider start to the serial restoring divider, one quotient bit per
// cycle, and then to the result register.
// A clear beat is taken in the idle state and produces no response beat.
// Reset is asynchronous and active low; it empties the window and needs no
// clearing pass, since a fill count marks which ring entries are live.
// A stalled response holds its beat; the next request is taken while the
// previous result still waits, and the sequencer waits for a free result register only at hand-off.
`default_nettype none

module moving_average_with_warmup #(
	parameter int WINDOW = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  req_valid,
	output logic                                       req_stall,
	input  wire logic                                  action,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
	output logic                                       rsp_valid,
	input  wire logic                                  rsp_stall,
	output logic signed [mavg_pkg::SAMPLE_W-1:0]       average
);

	// Commands and status between the sequencer and the datapath.
	mavg_pkg::cmd_t    cmd;
	mavg_pkg::status_t status;

	// The controller takes one request at a time: it accepts only in its idle
	// state and walks a sample beat through ring read, total update and division.
	mavg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (action),
		.req_stall (req_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath keeps the ring, the running total and the result register,
	// so a finished average waits there while the next request is processed.
	mavg_dpath #(
		.WINDOW(WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.average   (average)
	);

endmodule

`default_nettype wire

// ===== verif/mavg_checker.sv =====
// ----------------------------------------------------------------------------
// mavg_checker
// Watches both channels of the moving-average block, predicts every average
// from the accepted request beats, and compares each response beat with the
// oldest prediction. Reports a running count of failures.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_checker #(
	parameter int WINDOW = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  req_valid,
	input  wire logic                                  req_stall,
	input  wire logic                                  action,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  rsp_valid,
	input  wire logic                                  rsp_stall,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  average,
	output int                                         errors,
	output int                                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W = mavg_pkg::SAMPLE_W;
	localparam int TOTAL_W  = SAMPLE_W + $clog2(WINDOW);

	logic signed [SAMPLE_W-1:0] window_ring [WINDOW];
	logic signed [TOTAL_W-1:0]  window_sum;
	int unsigned                fill_slot;
	int unsigned                fill_count;
	logic signed [SAMPLE_W-1:0] averages_due [$];

	task automatic empty_window();
		for (int i = 0; i < WINDOW; i++) begin
			window_ring[i] = '0;
		end
		window_sum = '0;
		fill_slot  = 0;
		fill_count = 0;
	endtask

	// Folds one request beat into the window; a sample beat yields one average.
	task automatic fold_in_request(input logic act,
			input logic signed [SAMPLE_W-1:0] value);
		longint quotient;
		if (act == mavg_pkg::ACT_CLEAR) begin
			empty_window();
		end else begin
			window_sum = window_sum - window_ring[fill_slot] + value;
			window_ring[fill_slot] = value;
			fill_slot = (fill_slot == WINDOW - 1) ? 0 : fill_slot + 1;
			if (fill_count < WINDOW) begin
				fill_count++;
			end
			// Signed division in SystemVerilog truncates toward zero.
			quotient = longint'(window_sum) / longint'(fill_count);
			averages_due.push_back(quotient[SAMPLE_W-1:0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_window();
			averages_due.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (averages_due.size() == 0) begin
					$error("average: unexpected beat, got %0d", average);
					errors <= errors + 1;
				end else if (average !== averages_due[0]) begin
					$error("average mismatch: expected %0d, got %0d",
						averages_due[0], average);
					errors <= errors + 1;
					void'(averages_due.pop_front());
				end else begin
					void'(averages_due.pop_front());
				end
			end
			if (req_valid && !req_stall) begin
				fold_in_request(action, sample);
			end
			pending <= averages_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_moving_average_with_warmup.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_with_warmup
// Drives sample and clear beats into the moving-average block with random
// gaps and random response back-pressure, and leaves prediction and
// comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_moving_average_with_warmup;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W   = mavg_pkg::SAMPLE_W;
	localparam int WINDOW     = 16;
	localparam int LATENCY    = SAMPLE_W + $clog2(WINDOW) + 5;
	localparam int TAIL       = 3 * LATENCY;
	// Longest quiet spell in a correct run is one divide plus a long sender gap
	// plus a few chained long stalls; the limit sits far above that.
	localparam int IDLE_LIMIT = 5000;
	localparam int BEATS      = 1500;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	logic                       action    = mavg_pkg::ACT_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] average;
	int                         errors;
	int                         pending;
	int                         idle_cycles = 0;
	int                         stall_left  = 0;

	moving_average_with_warmup #(
		.WINDOW(WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action   (action),
		.sample   (sample),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.average  (average)
	);

	mavg_checker #(
		.WINDOW(WINDOW)
	) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action   (action),
		.sample   (sample),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.average  (average),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	// Values at the edges of the signed range and right around zero.
	function automatic logic signed [SAMPLE_W-1:0] edge_value();
		case ($urandom_range(0, 3))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7FFF;
			end
			2: begin
				return -16'sd1;
			end
			default: begin
				return 16'sd1;
			end
		endcase
	endfunction

	// Offers one beat, holds it until the block takes it, then optionally
	// drops valid for a gap. While valid is low the payload holds random junk
	// so that nothing downstream can lean on a stale value.
	task automatic send_beat(input logic act, input logic signed [SAMPLE_W-1:0] value,
			input int gap);
		req_valid <= 1'b1;
		action    <= act;
		sample    <= value;
		do begin
			@(posedge clk);
		end while (req_stall);
		if (gap != 0) begin
			req_valid <= 1'b0;
			action    <= 1'($urandom_range(0, 1));
			sample    <= SAMPLE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response back-pressure runs on its own: segments of stall or no stall
	// of random length, with an occasional long stretch of free flow so that
	// the block also gets to run flat out.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 19) == 0) begin
			rsp_stall  <= 1'b0;
			stall_left <= $urandom_range(100, 300);
		end else begin
			rsp_stall  <= ($urandom_range(0, 2) == 0);
			stall_left <= pick_gap();
		end
	end

	// Watchdog: any run of cycles in which neither channel moves a beat for
	// too long means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_moving_average_with_warmup: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int                         issued;
		int                         run_len;
		int                         mode;
		bit                         calm;
		logic signed [SAMPLE_W-1:0] run_value;
		logic signed [SAMPLE_W-1:0] value;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The very first beat lands on the state straight out
		// of reset, so the warm-up divisor starts at one.
		send_beat(mavg_pkg::ACT_SAMPLE, 16'sh7FFF, pick_gap());
		// A clear carries a junk sample that must be ignored.
		send_beat(mavg_pkg::ACT_CLEAR, 16'sh5A5A, pick_gap());
		// Warm-up truncation: -1 then 0 gives -1/2, which must round to zero.
		send_beat(mavg_pkg::ACT_SAMPLE, -16'sd1, pick_gap());
		send_beat(mavg_pkg::ACT_SAMPLE, 16'sd0, pick_gap());
		send_beat(mavg_pkg::ACT_CLEAR, 16'sd0, pick_gap());
		// A full window of the most negative value and one more, so the fill
		// count saturates, the write slot wraps and the sum hits its minimum.
		repeat (WINDOW + 1) send_beat(mavg_pkg::ACT_SAMPLE, 16'sh8000, pick_gap());
		// Mixing in the largest value makes the sum negative and not a
		// multiple of the window, so the steady-state divide must truncate.
		send_beat(mavg_pkg::ACT_SAMPLE, 16'sh7FFF, pick_gap());
		send_beat(mavg_pkg::ACT_SAMPLE, 16'sh7FFF, pick_gap());
		send_beat(mavg_pkg::ACT_SAMPLE, 16'sd1, pick_gap());

		// Random part, built from runs of one flavor of content. Long runs of
		// one value fill the whole window and reach the sum's extremes; small
		// values near zero exercise truncation of negative means; clears are
		// sprinkled in so warm-up is revisited again and again.
		issued = 0;
		while (issued < BEATS) begin
			mode      = $urandom_range(0, 3);
			run_len   = $urandom_range(1, 48);
			calm      = ($urandom_range(0, 5) == 0);
			run_value = ($urandom_range(0, 1) != 0) ? edge_value()
			                                       : SAMPLE_W'($urandom);
			repeat (run_len) begin
				case (mode)
					0: begin
						value = SAMPLE_W'($urandom);
					end
					1: begin
						value = $signed(SAMPLE_W'($urandom_range(0, 16))) - 16'sd8;
					end
					2: begin
						value = edge_value();
					end
					default: begin
						value = run_value;
					end
				endcase
				if ($urandom_range(0, 49) == 0) begin
					send_beat(mavg_pkg::ACT_CLEAR, SAMPLE_W'($urandom),
						calm ? 0 : pick_gap());
				end else begin
					send_beat(mavg_pkg::ACT_SAMPLE, value, calm ? 0 : pick_gap());
				end
				issued++;
			end
		end
		req_valid <= 1'b0;

		// Let the checker catch up with the last accepted beat, drain every
		// outstanding average, then give any stray beat time to show up.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0) begin
			$display("tb_moving_average_with_warmup: done, clean");
		end else begin
			$display("tb_moving_average_with_warmup: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== moving_average_with_warmup.f =====
+incdir+rtl/core
rtl/core/mavg_pkg.sv
rtl/core/mavg_div.sv
rtl/core/mavg_ctrl.sv
rtl/core/mavg_dpath.sv
rtl/core/moving_average_with_warmup.sv
verif/mavg_checker.sv
verif/tb_moving_average_with_warmup.sv
